FILE: hw/rtl/ubx_frame_parser_assert.svh
// ---------------------------------------------------------------------------
// ubx frame parser assertion macros
// shared property forms for the frame parser checkers
// ---------------------------------------------------------------------------
`ifndef UBX_FRAME_PARSER_ASSERT_SVH
`define UBX_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, reset disables
`define UBX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables
`define UBX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ubx_pkg.sv
// ---------------------------------------------------------------------------
// ubx_pkg
// types and constants shared by the frame parser controller and datapath
// ---------------------------------------------------------------------------
package ubx_pkg;

	localparam logic [7:0] SYNC1_BYTE = 8'hB5;
	localparam logic [7:0] SYNC2_BYTE = 8'h62;
	localparam logic [5:0] MAX_LEN_RST = 6'd52;

	typedef enum logic [3:0] {
		ST_SYNC1,
		ST_SYNC2,
		ST_CLASS,
		ST_ID,
		ST_LENLO,
		ST_LENHI,
		ST_DATA,
		ST_CKA,
		ST_CKB,
		ST_RD_ADDR,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		logic ld_class;
		logic ld_id;
		logic ld_lenlo;
		logic sum_add;
		logic clr_cnt;
		logic wr_data;
		logic clr_idx;
		logic step_idx;
		logic emit_single;
		logic emit_ok;
		logic emit_data;
	} cmd_t;

	typedef struct packed {
		logic sync1_hit;
		logic sync2_hit;
		logic len_over;
		logic len_zero_in;
		logic data_done;
		logic cka_match;
		logic ckb_match;
		logic len_zero;
		logic rd_last;
		logic out_free;
	} stat_t;

endpackage

FILE: hw/rtl/ubx_ctrl.sv
// ---------------------------------------------------------------------------
// ubx_ctrl
// frame phase state machine; issues datapath commands from status
// ---------------------------------------------------------------------------
module ubx_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ubx_pkg::stat_t st,
	output ubx_pkg::cmd_t  cmd
);

	ubx_pkg::state_t state_q;
	ubx_pkg::state_t state_d;
	logic            acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ubx_pkg::ST_SYNC1;
		end else begin
			state_q <= state_d;
		end
	end

	assign acc = in_valid & in_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b1;
		unique case (state_q)
			ubx_pkg::ST_SYNC1: begin
				if (acc && st.sync1_hit) begin
					state_d = ubx_pkg::ST_SYNC2;
				end
			end
			ubx_pkg::ST_SYNC2: begin
				if (acc) begin
					state_d = st.sync2_hit ? ubx_pkg::ST_CLASS : ubx_pkg::ST_SYNC1;
				end
			end
			ubx_pkg::ST_CLASS: begin
				if (acc) begin
					cmd.ld_class = 1'b1;
					state_d      = ubx_pkg::ST_ID;
				end
			end
			ubx_pkg::ST_ID: begin
				if (acc) begin
					cmd.ld_id   = 1'b1;
					cmd.sum_add = 1'b1;
					state_d     = ubx_pkg::ST_LENLO;
				end
			end
			ubx_pkg::ST_LENLO: begin
				if (acc) begin
					cmd.ld_lenlo = 1'b1;
					cmd.sum_add  = 1'b1;
					state_d      = ubx_pkg::ST_LENHI;
				end
			end
			ubx_pkg::ST_LENHI: begin
				if (acc) begin
					cmd.sum_add = 1'b1;
					cmd.clr_cnt = 1'b1;
					priority if (st.len_over) begin
						state_d = ubx_pkg::ST_SYNC1;
					end else if (st.len_zero_in) begin
						state_d = ubx_pkg::ST_CKA;
					end else begin
						state_d = ubx_pkg::ST_DATA;
					end
				end
			end
			ubx_pkg::ST_DATA: begin
				if (acc) begin
					cmd.sum_add = 1'b1;
					cmd.wr_data = 1'b1;
					if (st.data_done) begin
						state_d = ubx_pkg::ST_CKA;
					end
				end
			end
			ubx_pkg::ST_CKA: begin
				if (acc) begin
					state_d = st.cka_match ? ubx_pkg::ST_CKB : ubx_pkg::ST_SYNC1;
				end
			end
			ubx_pkg::ST_CKB: begin
				in_ready = st.out_free;
				if (acc) begin
					priority if (!st.ckb_match) begin
						cmd.emit_single = 1'b1;
						state_d         = ubx_pkg::ST_SYNC1;
					end else if (st.len_zero) begin
						cmd.emit_single = 1'b1;
						cmd.emit_ok     = 1'b1;
						state_d         = ubx_pkg::ST_SYNC1;
					end else begin
						cmd.clr_idx = 1'b1;
						state_d     = ubx_pkg::ST_RD_ADDR;
					end
				end
			end
			ubx_pkg::ST_RD_ADDR: begin
				in_ready = 1'b0;
				state_d  = ubx_pkg::ST_RD_OUT;
			end
			ubx_pkg::ST_RD_OUT: begin
				in_ready = 1'b0;
				if (st.out_free) begin
					cmd.emit_data = 1'b1;
					cmd.step_idx  = 1'b1;
					state_d       = st.rd_last ? ubx_pkg::ST_SYNC1 : ubx_pkg::ST_RD_ADDR;
				end
			end
			default: begin
				state_d = ubx_pkg::ST_SYNC1;
			end
		endcase
	end

endmodule

FILE: hw/rtl/ubx_dpath.sv
// ---------------------------------------------------------------------------
// ubx_dpath
// header registers, fletcher sums, payload buffer and result register
// ---------------------------------------------------------------------------
module ubx_dpath #(
	parameter int MAX_PAYLOAD = 52
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     rx_byte,
	input  logic           cfg_wr_en,
	input  logic [5:0]     cfg_wr_data,
	input  ubx_pkg::cmd_t  cmd,
	output ubx_pkg::stat_t st,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [7:0]     msg_class,
	output logic [7:0]     msg_id,
	output logic [5:0]     payload_len,
	output logic [5:0]     byte_index,
	output logic [7:0]     payload_byte,
	output logic           frame_ok,
	output logic           last
);

	localparam int         AW    = $clog2(MAX_PAYLOAD);
	localparam int         CW    = $clog2(MAX_PAYLOAD + 1);
	localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

	logic [5:0]    max_len_q;
	logic [7:0]    class_q;
	logic [7:0]    id_q;
	logic [7:0]    len_q;
	logic [7:0]    ck_a_q;
	logic [7:0]    ck_b_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] rd_idx_q;
	logic [7:0]    mem [MAX_PAYLOAD];
	logic [7:0]    rd_data_q;
	logic [7:0]    sum_a;
	logic [7:0]    cnt_inc;
	logic [7:0]    idx_inc;
	logic          out_load;

	logic       out_valid_q;
	logic [7:0] msg_class_q;
	logic [7:0] msg_id_q;
	logic [5:0] payload_len_q;
	logic [5:0] byte_index_q;
	logic [7:0] payload_byte_q;
	logic       frame_ok_q;
	logic       last_q;

	assign sum_a   = ck_a_q + rx_byte;
	assign cnt_inc = 8'(cnt_q) + 8'd1;
	assign idx_inc = 8'(rd_idx_q) + 8'd1;

	always_comb begin
		st             = '0;
		st.sync1_hit   = (rx_byte == ubx_pkg::SYNC1_BYTE);
		st.sync2_hit   = (rx_byte == ubx_pkg::SYNC2_BYTE);
		st.len_over    = (rx_byte != 8'd0) || (len_q > {2'b00, max_len_q}) || (len_q > MAX_B);
		st.len_zero_in = (rx_byte == 8'd0) && (len_q == 8'd0);
		st.data_done   = (cnt_inc >= len_q) || (cnt_inc >= MAX_B);
		st.cka_match   = (rx_byte == ck_a_q);
		st.ckb_match   = (rx_byte == ck_b_q);
		st.len_zero    = (len_q == 8'd0);
		st.rd_last     = (idx_inc == len_q);
		st.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= ubx_pkg::MAX_LEN_RST;
			class_q   <= '0;
			id_q      <= '0;
			len_q     <= '0;
			ck_a_q    <= '0;
			ck_b_q    <= '0;
			cnt_q     <= '0;
			rd_idx_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
			if (cmd.ld_class) begin
				class_q <= rx_byte;
				ck_a_q  <= rx_byte;
				ck_b_q  <= rx_byte;
			end
			if (cmd.ld_id) begin
				id_q <= rx_byte;
			end
			if (cmd.ld_lenlo) begin
				len_q <= rx_byte;
			end
			if (cmd.sum_add) begin
				ck_a_q <= sum_a;
				ck_b_q <= ck_b_q + sum_a;
			end
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.wr_data && (cnt_q < CW'(MAX_PAYLOAD))) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.clr_idx) begin
				rd_idx_q <= '0;
			end else if (cmd.step_idx) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
		end
	end

	// payload buffer
	always_ff @(posedge clk) begin
		if (cmd.wr_data && (cnt_q < CW'(MAX_PAYLOAD))) begin
			mem[cnt_q[AW-1:0]] <= rx_byte;
		end
		rd_data_q <= mem[rd_idx_q];
	end

	assign out_load = cmd.emit_single || cmd.emit_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			msg_class_q   <= class_q;
			msg_id_q      <= id_q;
			payload_len_q <= len_q[5:0];
			if (cmd.emit_data) begin
				byte_index_q   <= 6'(rd_idx_q);
				payload_byte_q <= rd_data_q;
				frame_ok_q     <= 1'b1;
				last_q         <= (idx_inc == len_q);
			end else begin
				byte_index_q   <= '0;
				payload_byte_q <= '0;
				frame_ok_q     <= cmd.emit_ok;
				last_q         <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign msg_class    = msg_class_q;
	assign msg_id       = msg_id_q;
	assign payload_len  = payload_len_q;
	assign byte_index   = byte_index_q;
	assign payload_byte = payload_byte_q;
	assign frame_ok     = frame_ok_q;
	assign last         = last_q;

endmodule

FILE: hw/rtl/ubx_frame_parser.sv
// ---------------------------------------------------------------------------
// ubx_frame_parser
// sync-pair frame parser with 8-bit fletcher checksum and payload readout
// ---------------------------------------------------------------------------
// Takes one received word per cycle in every parse phase, except that the
// checksum B word waits until the result register is free. A good frame with
// payload then reads its buffered bytes out through the registered read port
// of the payload buffer; no input is taken during that run. Bad-checksum-B and
// zero-length frames give one result. The length limit written through
// cfg_wr_data caps the accepted payload length (reset 52).
module ubx_frame_parser #(
	parameter int MAX_PAYLOAD = 52
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       cfg_wr_en,
	input  logic [5:0] cfg_wr_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] msg_class,
	output logic [7:0] msg_id,
	output logic [5:0] payload_len,
	output logic [5:0] byte_index,
	output logic [7:0] payload_byte,
	output logic       frame_ok,
	output logic       last
);

	ubx_pkg::cmd_t  cmd;
	ubx_pkg::stat_t st;

	ubx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	ubx_dpath #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.st           (st),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.msg_class    (msg_class),
		.msg_id       (msg_id),
		.payload_len  (payload_len),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.frame_ok     (frame_ok),
		.last         (last)
	);

endmodule

FILE: hw/rtl/ubx_chk.sv
// ---------------------------------------------------------------------------
// ubx_chk
// port-level checks of the frame parser result stream
// ---------------------------------------------------------------------------
`include "ubx_frame_parser_assert.svh"

module ubx_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] byte_index,
	input logic [7:0] payload_byte,
	input logic       frame_ok,
	input logic       last
);

	// stalled word holds
	`UBX_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(payload_byte) && $stable(last), "result word changed while stalled")

	// bad frame word is a single empty result
	`UBX_ASSERT_NOW(a_bad_word, clk, arst_n, out_valid && !frame_ok, last && (byte_index == 6'd0) && (payload_byte == 8'd0), "bad frame word malformed")

	// no input taken in the middle of a readout run
	`UBX_ASSERT_NOW(a_run_block, clk, arst_n, out_valid && !last, !in_ready, "input taken during readout run")

endmodule

bind ubx_frame_parser ubx_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.byte_index   (byte_index),
	.payload_byte (payload_byte),
	.frame_ok     (frame_ok),
	.last         (last)
);

FILE: tb/tb_ubx_frame_parser.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ubx_frame_parser
// self-checking bench for the sync-pair frame parser
// ---------------------------------------------------------------------------
// Feeds framed and unframed words into the parser with random gaps and output
// stalls. A predictor tracks the parse phase, the fletcher sums and the payload
// buffer, and queues the result words each input word should produce. Every
// result word is compared field by field against that queue. Covers sync
// hunting, empty frames, overlong and checksum failures, output backpressure
// and several payload length limits.
// ---------------------------------------------------------------------------
module tb_ubx_frame_parser;

	localparam int MAX_PAYLOAD = 52;

	typedef struct packed {
		logic [7:0] cls;
		logic [7:0] id;
		logic [5:0] len;
		logic [5:0] idx;
		logic [7:0] data;
		logic       ok;
		logic       lst;
	} frame_word_t;

	typedef enum {FR_GOOD, FR_BAD_CKA, FR_BAD_CKB, FR_OVERLONG} frame_fault_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       cfg_wr_en = 1'b0;
	logic [5:0] cfg_wr_data = 6'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] msg_class;
	logic [7:0] msg_id;
	logic [5:0] payload_len;
	logic [5:0] byte_index;
	logic [7:0] payload_byte;
	logic       frame_ok;
	logic       last;

	// predictor state
	ubx_pkg::state_t pr_phase = ubx_pkg::ST_SYNC1;
	logic [7:0]      pr_class = 8'h00;
	logic [7:0]      pr_id = 8'h00;
	logic [15:0]     pr_len = 16'h0000;
	int              pr_cnt = 0;
	logic [7:0]      pr_sum_a = 8'h00;
	logic [7:0]      pr_sum_b = 8'h00;
	logic [7:0]      pr_buf [MAX_PAYLOAD];
	logic [5:0]      max_len_cfg = ubx_pkg::MAX_LEN_RST;

	frame_word_t frame_words_q[$];
	int          n_mismatch = 0;
	int          frame_bytes = 0;
	int          tx_idle_pct = 0;
	bit          tx_live = 0;
	bit          quiet = 0;
	int          rdy_hold = 0;

	ubx_frame_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.msg_class   (msg_class),
		.msg_id      (msg_id),
		.payload_len (payload_len),
		.byte_index  (byte_index),
		.payload_byte(payload_byte),
		.frame_ok    (frame_ok),
		.last        (last)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int len_limit();
		return (max_len_cfg < MAX_PAYLOAD) ? int'(max_len_cfg) : MAX_PAYLOAD;
	endfunction

	function automatic void fold_sum(input logic [7:0] d);
		pr_sum_a = pr_sum_a + d;
		pr_sum_b = pr_sum_b + pr_sum_a;
	endfunction

	function automatic void queue_word(input int idx, input logic [7:0] data,
		input logic ok, input logic lst);
		frame_words_q.push_back('{pr_class, pr_id, pr_len[5:0], 6'(idx), data, ok, lst});
	endfunction

	// advance the parse model by one accepted word
	function automatic void track_parser(input logic [7:0] d);
		int n;
		case (pr_phase)
			ubx_pkg::ST_SYNC2: begin
				pr_phase = (d == ubx_pkg::SYNC2_BYTE) ? ubx_pkg::ST_CLASS : ubx_pkg::ST_SYNC1;
			end
			ubx_pkg::ST_CLASS: begin
				pr_class = d;
				pr_sum_a = d;
				pr_sum_b = d;
				pr_phase = ubx_pkg::ST_ID;
			end
			ubx_pkg::ST_ID: begin
				pr_id = d;
				fold_sum(d);
				pr_phase = ubx_pkg::ST_LENLO;
			end
			ubx_pkg::ST_LENLO: begin
				pr_len = {8'h00, d};
				fold_sum(d);
				pr_phase = ubx_pkg::ST_LENHI;
			end
			ubx_pkg::ST_LENHI: begin
				pr_len[15:8] = d;
				fold_sum(d);
				pr_cnt = 0;
				if (pr_len > len_limit())
					pr_phase = ubx_pkg::ST_SYNC1;
				else if (pr_len == 0)
					pr_phase = ubx_pkg::ST_CKA;
				else
					pr_phase = ubx_pkg::ST_DATA;
			end
			ubx_pkg::ST_DATA: begin
				fold_sum(d);
				if (pr_cnt < MAX_PAYLOAD) begin
					pr_buf[pr_cnt] = d;
					pr_cnt++;
				end
				if (pr_cnt >= pr_len || pr_cnt >= MAX_PAYLOAD)
					pr_phase = ubx_pkg::ST_CKA;
			end
			ubx_pkg::ST_CKA: begin
				pr_phase = (d == pr_sum_a) ? ubx_pkg::ST_CKB : ubx_pkg::ST_SYNC1;
			end
			ubx_pkg::ST_CKB: begin
				if (d != pr_sum_b) begin
					queue_word(0, 8'h00, 1'b0, 1'b1);
				end else if (pr_len == 0) begin
					queue_word(0, 8'h00, 1'b1, 1'b1);
				end else begin
					n = (pr_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(pr_len);
					for (int k = 0; k < n; k++)
						queue_word(k, pr_buf[k], 1'b1, k + 1 == n);
				end
				pr_phase = ubx_pkg::ST_SYNC1;
			end
			default: begin
				pr_phase = (d == ubx_pkg::SYNC1_BYTE) ? ubx_pkg::ST_SYNC2 : ubx_pkg::ST_SYNC1;
			end
		endcase
	endfunction

	task automatic cmp_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			n_mismatch++;
		end
	endtask

	always @(posedge clk) begin : check_words
		frame_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_words_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, got class %0h id %0h idx %0d",
					$time, msg_class, msg_id, byte_index);
				n_mismatch++;
			end else begin
				want = frame_words_q.pop_front();
				cmp_field("msg_class", want.cls, msg_class);
				cmp_field("msg_id", want.id, msg_id);
				cmp_field("payload_len", 8'(want.len), 8'(payload_len));
				cmp_field("byte_index", 8'(want.idx), 8'(byte_index));
				cmp_field("payload_byte", want.data, payload_byte);
				cmp_field("frame_ok", 8'(want.ok), 8'(frame_ok));
				cmp_field("last", 8'(want.lst), 8'(last));
			end
		end
	end

	// receiver side: random stall bursts, calm stretches, long hold on request
	initial begin : rx_side
		int stall;
		int calm;
		stall = 0;
		calm = 0;
		forever begin
			@(posedge clk);
			if (rdy_hold > 0) begin
				out_ready <= 1'b0;
				rdy_hold--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				if (calm > 0)
					calm--;
				else if ($urandom_range(0, 99) < 3)
					calm = $urandom_range(20, 120);
				if (!quiet && calm == 0 && $urandom_range(0, 99) < 20) begin
					stall = $urandom_range(1, 17) - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	task automatic tx_stop();
		if (tx_live) begin
			in_valid <= 1'b0;
			tx_live = 0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
			gap = $urandom_range(1, 17);
		if (gap > 0) begin
			tx_stop();
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		tx_live = 1;
		do @(posedge clk); while (!in_ready);
		track_parser(b);
	endtask

	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
		input logic [15:0] len, input frame_fault_t fault);
		logic [7:0] fb[$];
		logic [7:0] sa;
		logic [7:0] sb;
		case ($urandom_range(0, 3))
			0: tx_idle_pct = 0;
			1: tx_idle_pct = 10;
			2: tx_idle_pct = 30;
			default: tx_idle_pct = 60;
		endcase
		fb = {ubx_pkg::SYNC1_BYTE, ubx_pkg::SYNC2_BYTE, cls, id, len[7:0], len[15:8]};
		if (fault != FR_OVERLONG) begin
			for (int i = 0; i < len; i++)
				fb.push_back(8'($urandom_range(0, 255)));
			sa = 8'h00;
			sb = 8'h00;
			for (int i = 2; i < fb.size(); i++) begin
				sa = sa + fb[i];
				sb = sb + sa;
			end
			if (fault == FR_BAD_CKA)
				sa = sa ^ 8'($urandom_range(1, 255));
			if (fault == FR_BAD_CKB)
				sb = sb ^ 8'($urandom_range(1, 255));
			fb.push_back(sa);
			fb.push_back(sb);
		end
		foreach (fb[k])
			send_byte(fb[k]);
		frame_bytes += fb.size();
	endtask

	task automatic wait_drained();
		tx_stop();
		while (frame_words_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_max_len(input logic [5:0] v);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_len_cfg = v;
	endtask

	task automatic test_sync_hunt();
		// bad second sync word is not taken as a new first sync
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(ubx_pkg::SYNC1_BYTE);
		send_byte(ubx_pkg::SYNC1_BYTE);
		send_byte(ubx_pkg::SYNC2_BYTE);
		send_byte(ubx_pkg::SYNC1_BYTE);
		send_byte(8'h00);
	endtask

	task automatic test_empty_frames();
		send_frame(8'hFF, 8'h00, 16'd0, FR_GOOD);
		send_frame(8'h00, 8'hFF, 16'd0, FR_BAD_CKA);
	endtask

	task automatic test_overlong_header();
		send_frame(8'h5A, 8'hA5, 16'h0100, FR_OVERLONG);
	endtask

	task automatic test_output_backpressure();
		send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			16'(MAX_PAYLOAD), FR_GOOD);
		// receiver holds off while the readout run and the next frame are pending
		rdy_hold = 300;
		send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd4, FR_GOOD);
		send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd0, FR_BAD_CKB);
	endtask

	task automatic test_drain_pause();
		send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd5, FR_GOOD);
		wait_drained();
		send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd2, FR_BAD_CKB);
		wait_drained();
	endtask

	task automatic test_max_len_sweep();
		logic [5:0] sweep [3];
		int lim;
		sweep = '{6'd0, 6'd7, 6'($urandom_range(0, 15))};
		foreach (sweep[s]) begin
			set_max_len(sweep[s]);
			lim = len_limit();
			send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				16'(lim), FR_GOOD);
			send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				16'(lim + 1), FR_OVERLONG);
		end
	endtask

	task automatic test_random_traffic();
		int pick;
		int lim;
		logic [15:0] len;
		frame_bytes = 0;
		for (int half = 0; half < 2; half++) begin
			set_max_len((half == 0) ? 6'd63 : 6'($urandom_range(10, 52)));
			lim = len_limit();
			while (frame_bytes < 20 * (half + 1)) begin
				quiet = (frame_bytes >= 25);
				pick = $urandom_range(0, 99);
				if ($urandom_range(0, 9) == 0)
					len = 16'($urandom_range(0, lim));
				else
					len = 16'($urandom_range(0, (lim < 12) ? lim : 12));
				if (pick < 60) begin
					send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
						FR_GOOD);
				end else if (pick < 72) begin
					send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
						FR_BAD_CKB);
				end else if (pick < 82) begin
					send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
						FR_BAD_CKA);
				end else if (pick < 90) begin
					if ($urandom_range(0, 1))
						len = 16'(lim + 1 + $urandom_range(0, 3));
					else
						len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
					send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
						FR_OVERLONG);
				end else begin
					// line noise, broken sync pairs and cut-off headers
					case ($urandom_range(0, 2))
						0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
						1: begin
							send_byte(ubx_pkg::SYNC1_BYTE);
							send_byte(8'($urandom_range(0, 255)) ^ ubx_pkg::SYNC2_BYTE ^ 8'h01);
						end
						default: begin
							send_byte(ubx_pkg::SYNC1_BYTE);
							send_byte(ubx_pkg::SYNC2_BYTE);
							repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
						end
					endcase
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sync_hunt();
		test_empty_frames();
		test_overlong_header();
		test_output_backpressure();
		test_drain_pause();
		test_max_len_sweep();
		test_random_traffic();
		wait_drained();
		repeat (40) @(posedge clk);
		if (n_mismatch == 0 && frame_words_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
